/* design/traffic_light_sequencer_core_assert.svh */
// Assertion macros of the traffic light sequencer core.
`ifndef TRAFFIC_LIGHT_SEQUENCER_CORE_ASSERT_SVH
`define TRAFFIC_LIGHT_SEQUENCER_CORE_ASSERT_SVH

// checked outside reset
`define TLS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked in every cycle, reset included
`define TLS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/tls_pkg.sv */
// Types, constants and helpers of the traffic light sequencer.
package tls_pkg;

   localparam int COUNT_BITS = 16;
   localparam int CFG_BITS   = 16;
   localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
   localparam int ADDR_BITS  = 5;
   localparam int IDX_BITS   = 3;

   typedef logic [COUNT_BITS-1:0] age_type;
   typedef logic [CFG_BITS-1:0]   dur_type;
   typedef logic [CMP_BITS-1:0]   cmp_type;
   typedef logic [IDX_BITS-1:0]   reg_idx_type;

   localparam age_type AGE_MAX = '1;

   localparam reg_idx_type REG_RED          = 3'd0;
   localparam reg_idx_type REG_RED_YELLOW   = 3'd1;
   localparam reg_idx_type REG_GREEN        = 3'd2;
   localparam reg_idx_type REG_GREEN_FLASH  = 3'd3;
   localparam reg_idx_type REG_YELLOW       = 3'd4;
   localparam reg_idx_type REG_DEBOUNCE     = 3'd5;
   localparam reg_idx_type REG_BLINK_PERIOD = 3'd6;

   localparam dur_type RST_RED          = 16'd3000;
   localparam dur_type RST_RED_YELLOW   = 16'd1000;
   localparam dur_type RST_GREEN        = 16'd3000;
   localparam dur_type RST_GREEN_FLASH  = 16'd2000;
   localparam dur_type RST_YELLOW       = 16'd1000;
   localparam dur_type RST_DEBOUNCE     = 16'd50;
   localparam dur_type RST_BLINK_PERIOD = 16'd200;

   typedef enum logic [2:0] {
      PH_RED          = 3'd0,
      PH_RED_YELLOW   = 3'd1,
      PH_GREEN        = 3'd2,
      PH_GREEN_FLASH  = 3'd3,
      PH_YELLOW       = 3'd4,
      PH_YELLOW_BLINK = 3'd5
   } phase_type;

   typedef struct packed {
      dur_type red;
      dur_type red_yellow;
      dur_type green;
      dur_type green_flash;
      dur_type yellow;
      dur_type debounce;
      dur_type blink_period;
   } cfg_type;

   typedef struct packed {
      phase_type phase;
      age_type   phase_age;
      age_type   blink_age;
      logic      blink_lamp_on;
      age_type   press_age;
   } state_type;

   typedef struct packed {
      logic      red_on;
      logic      yellow_on;
      logic      green_on;
      phase_type phase;
   } lamps_type;

   function automatic age_type age_inc(input age_type a);
      return (a == AGE_MAX) ? a : a + age_type'(1);
   endfunction

   function automatic logic age_ge(input age_type a, input dur_type d);
      return cmp_type'(a) >= cmp_type'(d);
   endfunction

endpackage

/* design/tls_csr.sv */
// Configuration register file with its APB-style access port.
module tls_csr
   import tls_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output cfg_type              cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   dur_type     wval;
   dur_type     rval;

   assign idx        = csr_paddr[ADDR_BITS-1:2];
   assign wval       = csr_pwdata[CFG_BITS-1:0];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (idx)
            REG_RED:          cfg_in.red          = wval;
            REG_RED_YELLOW:   cfg_in.red_yellow   = wval;
            REG_GREEN:        cfg_in.green        = wval;
            REG_GREEN_FLASH:  cfg_in.green_flash  = wval;
            REG_YELLOW:       cfg_in.yellow       = wval;
            REG_DEBOUNCE:     cfg_in.debounce     = wval;
            REG_BLINK_PERIOD: cfg_in.blink_period = wval;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_RED:          rval = cfg_ff.red;
         REG_RED_YELLOW:   rval = cfg_ff.red_yellow;
         REG_GREEN:        rval = cfg_ff.green;
         REG_GREEN_FLASH:  rval = cfg_ff.green_flash;
         REG_YELLOW:       rval = cfg_ff.yellow;
         REG_DEBOUNCE:     rval = cfg_ff.debounce;
         REG_BLINK_PERIOD: rval = cfg_ff.blink_period;
         default:          rval = '0;
      endcase
   end

   assign csr_prdata = {{(32-CFG_BITS){1'b0}}, rval};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red          <= RST_RED;
         cfg_ff.red_yellow   <= RST_RED_YELLOW;
         cfg_ff.green        <= RST_GREEN;
         cfg_ff.green_flash  <= RST_GREEN_FLASH;
         cfg_ff.yellow       <= RST_YELLOW;
         cfg_ff.debounce     <= RST_DEBOUNCE;
         cfg_ff.blink_period <= RST_BLINK_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/tls_step.sv */
// Next-state and lamp logic for one tick of the sequencer.
module tls_step
   import tls_pkg::*;
(
   input  state_type st,
   input  cfg_type   cfg,
   input  logic      button_fall,
   output state_type nxt,
   output lamps_type lamps
);

   always_comb begin
      nxt           = st;
      nxt.phase_age = age_inc(st.phase_age);
      nxt.blink_age = age_inc(st.blink_age);
      nxt.press_age = age_inc(st.press_age);

      if (button_fall && age_ge(nxt.press_age, cfg.debounce)) begin
         nxt.press_age = '0;
         nxt.phase_age = '0;
         if (st.phase == PH_YELLOW_BLINK) begin
            nxt.phase = PH_RED;
         end else begin
            nxt.phase         = PH_YELLOW_BLINK;
            nxt.blink_age     = '0;
            nxt.blink_lamp_on = 1'b0;
         end
      end

      case (nxt.phase)
         PH_RED: begin
            if (age_ge(nxt.phase_age, cfg.red)) begin
               nxt.phase     = PH_RED_YELLOW;
               nxt.phase_age = '0;
            end
         end
         PH_RED_YELLOW: begin
            if (age_ge(nxt.phase_age, cfg.red_yellow)) begin
               nxt.phase     = PH_GREEN;
               nxt.phase_age = '0;
            end
         end
         PH_GREEN: begin
            if (age_ge(nxt.phase_age, cfg.green)) begin
               nxt.phase         = PH_GREEN_FLASH;
               nxt.phase_age     = '0;
               nxt.blink_age     = '0;
               nxt.blink_lamp_on = 1'b0;
            end
         end
         PH_GREEN_FLASH: begin
            if (age_ge(nxt.phase_age, cfg.green_flash)) begin
               nxt.phase     = PH_YELLOW;
               nxt.phase_age = '0;
            end else if (age_ge(nxt.blink_age, cfg.blink_period)) begin
               nxt.blink_age     = '0;
               nxt.blink_lamp_on = ~nxt.blink_lamp_on;
            end
         end
         PH_YELLOW: begin
            if (age_ge(nxt.phase_age, cfg.yellow)) begin
               nxt.phase     = PH_RED;
               nxt.phase_age = '0;
            end
         end
         PH_YELLOW_BLINK: begin
            if (age_ge(nxt.blink_age, cfg.blink_period)) begin
               nxt.blink_age     = '0;
               nxt.blink_lamp_on = ~nxt.blink_lamp_on;
            end
         end
         default: begin
            nxt.phase     = PH_RED;
            nxt.phase_age = '0;
         end
      endcase
   end

   always_comb begin
      lamps           = '0;
      lamps.phase     = nxt.phase;
      case (nxt.phase)
         PH_RED:          lamps.red_on    = 1'b1;
         PH_RED_YELLOW: begin
            lamps.red_on    = 1'b1;
            lamps.yellow_on = 1'b1;
         end
         PH_GREEN:        lamps.green_on  = 1'b1;
         PH_GREEN_FLASH:  lamps.green_on  = nxt.blink_lamp_on;
         PH_YELLOW:       lamps.yellow_on = 1'b1;
         PH_YELLOW_BLINK: lamps.yellow_on = nxt.blink_lamp_on;
         default:         lamps.red_on    = 1'b0;
      endcase
   end

endmodule

/* design/traffic_light_sequencer_core.sv */
// Top level of the traffic light sequencer: tick register, state and result register.
//
//  port group | role                  | beat contents
//  req_*      | tick in, stream slave | tdata[0] button_fall
//  rsp_*      | lamps out, stream mst | tdata[0] red, [1] yellow, [2] green, [5:3] phase
//  csr_*      | APB-style config      | 7 x 16-bit duration registers at 4*i
//
// One tick accepted per cycle unless a stalled rsp holds it back.
// A tick passes the tick register and then the result register; state advances as a tick
// moves into the result register.
// A stalled rsp holds its beat; req stays ready while the tick register can drain.
// Synchronous reset restores register defaults and the red phase.
module traffic_light_sequencer_core
   import tls_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [0] button_fall, [7:1] zero
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [0] red_on [1] yellow_on [2] green_on [5:3] phase
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   cfg_type   cfg;
   state_type st_ff;
   state_type nxt;
   lamps_type lamps;
   lamps_type lamps_ff;
   logic      in_valid_ff;
   logic      in_valid_in;
   logic      in_button_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      adv;

   tls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tls_step u_step (
      .st          (st_ff),
      .cfg         (cfg),
      .button_fall (in_button_ff),
      .nxt         (nxt),
      .lamps       (lamps)
   );

   assign adv          = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || adv;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !adv);
   assign out_valid_in = adv || (out_valid_ff && !rsp_tready);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, lamps_ff.phase, lamps_ff.green_on,
                        lamps_ff.yellow_on, lamps_ff.red_on};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         st_ff.phase         <= PH_RED;
         st_ff.phase_age     <= '0;
         st_ff.blink_age     <= '0;
         st_ff.blink_lamp_on <= 1'b0;
         st_ff.press_age     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            st_ff <= nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_button_ff <= req_tdata[0];
      end
      if (adv) begin
         lamps_ff <= lamps;
      end
   end

`include "traffic_light_sequencer_core_assert.svh"

   `TLS_ASSERT(a_no_red_green, rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[2]), "red and green lit together")
   `TLS_ASSERT(a_state_hold, !adv |=> $stable(st_ff), "state moved without a tick")
   `TLS_ASSERT(a_age_clear, (adv && nxt.phase != st_ff.phase) |=> st_ff.phase_age == '0, "phase age not cleared on phase change")
   `TLS_ASSERT(a_blink_by_press, (adv && nxt.phase == PH_YELLOW_BLINK && st_ff.phase != PH_YELLOW_BLINK) |-> in_button_ff, "yellow blink entered without a press")
   `TLS_ASSERT_ALWAYS(a_reset_state, reset |=> (!out_valid_ff && st_ff.phase == PH_RED), "reset did not clear state")

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the traffic light sequencer core: stream ticks in, lamp beats out.
`timescale 1ns / 1ps

module testbench;
   import tls_pkg::*;

   localparam int unsigned LIMIT       = 1000000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_PAUSE = 8;
   localparam reg_idx_type REG_UNUSED  = 3'd7;

   typedef struct {
      logic      red;
      logic      yellow;
      logic      green;
      phase_type phase;
   } lamp_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;   // [0] button_fall, [7:1] zero
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;        // [0] red [1] yellow [2] green [5:3] phase [7:6] zero
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]          csr_pwdata = '0;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   traffic_light_sequencer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // light model state
   dur_type       dur_cfg [0:6];
   phase_type     cur_phase = PH_RED;
   age_type       phase_age = '0;
   age_type       blink_age = '0;
   age_type       press_age = '0;
   logic          lamp_on   = 1'b0;
   lamp_beat_type lamps_due [$];

   bit          tick_q [$];
   int unsigned ticks_queued = 0;
   int unsigned ticks_taken  = 0;
   int unsigned rsp_beats    = 0;
   int unsigned error_count  = 0;
   int unsigned cycle_count  = 0;
   bit          tick_taken   = 1'b0;
   bit          idle_on      = 1'b0;
   bit          hold_req     = 1'b0;
   int unsigned send_gap     = 0;
   int unsigned stall_left   = 0;
   int unsigned hold_left    = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic age_type age_step(age_type a);
      return a + age_type'(a != AGE_MAX);
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      $display("mismatch at lamp beat %0d: %s got %0d want %0d", rsp_beats, what, got, want);
      error_count++;
   endtask

   task automatic enter_phase(phase_type p);
      cur_phase = p;
      phase_age = '0;
      if (p == PH_GREEN_FLASH || p == PH_YELLOW_BLINK) begin
         blink_age = '0;
         lamp_on   = 1'b0;
      end
   endtask

   task automatic blink_step();
      if (blink_age >= dur_cfg[REG_BLINK_PERIOD]) begin
         blink_age = '0;
         lamp_on   = ~lamp_on;
      end
   endtask

   task automatic advance_light(bit button_fall);
      lamp_beat_type nxt;
      phase_age = age_step(phase_age);
      blink_age = age_step(blink_age);
      press_age = age_step(press_age);
      if (button_fall && press_age >= dur_cfg[REG_DEBOUNCE]) begin
         press_age = '0;
         enter_phase((cur_phase == PH_YELLOW_BLINK) ? PH_RED : PH_YELLOW_BLINK);
      end
      case (cur_phase)
         PH_RED: if (phase_age >= dur_cfg[REG_RED]) enter_phase(PH_RED_YELLOW);
         PH_RED_YELLOW: if (phase_age >= dur_cfg[REG_RED_YELLOW]) enter_phase(PH_GREEN);
         PH_GREEN: if (phase_age >= dur_cfg[REG_GREEN]) enter_phase(PH_GREEN_FLASH);
         PH_GREEN_FLASH: begin
            if (phase_age >= dur_cfg[REG_GREEN_FLASH]) enter_phase(PH_YELLOW);
            else blink_step();
         end
         PH_YELLOW: if (phase_age >= dur_cfg[REG_YELLOW]) enter_phase(PH_RED);
         PH_YELLOW_BLINK: blink_step();
         default: enter_phase(PH_RED);
      endcase
      nxt.phase  = cur_phase;
      nxt.red    = (cur_phase == PH_RED) || (cur_phase == PH_RED_YELLOW);
      nxt.yellow = (cur_phase == PH_RED_YELLOW) || (cur_phase == PH_YELLOW)
                   || (cur_phase == PH_YELLOW_BLINK && lamp_on);
      nxt.green  = (cur_phase == PH_GREEN) || (cur_phase == PH_GREEN_FLASH && lamp_on);
      lamps_due.push_back(nxt);
   endtask

   task automatic check_lamps(logic [7:0] d);
      lamp_beat_type want;
      if (lamps_due.size() == 0) begin
         flag_mismatch("unexpected beat, tdata", d, 0);
      end else begin
         want = lamps_due.pop_front();
         if (d[0] !== want.red) flag_mismatch("red_on", d[0], want.red);
         if (d[1] !== want.yellow) flag_mismatch("yellow_on", d[1], want.yellow);
         if (d[2] !== want.green) flag_mismatch("green_on", d[2], want.green);
         if (d[5:3] !== want.phase) flag_mismatch("phase", d[5:3], want.phase);
      end
      rsp_beats++;
   endtask

   // tick driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !tick_taken) begin
         // hold the offered beat
      end else if (send_gap > 0) begin
         req_tvalid <= 1'b0;
         send_gap--;
      end else if (tick_q.size() > 0) begin
         req_tdata  <= {7'b0, tick_q.pop_front()};
         req_tvalid <= 1'b1;
         send_gap   = idle_on ? pick_gap() : 0;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // lamp sink with random stalls and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_req) begin
         hold_req   = 1'b0;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = idle_on ? pick_gap() : 0;
      end
   end

   // monitor: predict on tick beats, check lamp beats
   always @(posedge clock) begin
      if (reset) begin
         tick_taken = 1'b0;
      end else begin
         tick_taken = req_tvalid && req_tready;
         if (tick_taken) begin
            advance_light(req_tdata[0]);
            ticks_taken++;
         end
         if (rsp_tvalid && rsp_tready) check_lamps(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic csr_write(reg_idx_type idx, dur_type val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= {16'($urandom), val};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx <= REG_BLINK_PERIOD) dur_cfg[idx] = val;
   endtask

   task automatic queue_ticks(int unsigned count, int unsigned press_odds);
      @(posedge clock);
      for (int unsigned i = 0; i < count; i++)
         tick_q.push_back($urandom_range(0, press_odds - 1) == 0);
      ticks_queued += count;
   endtask

   task automatic wait_idle();
      while (ticks_taken != ticks_queued || lamps_due.size() != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   function automatic dur_type rand_dur();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return dur_type'(1);
      if (r == 2) return '1;
      return dur_type'($urandom_range(2, 15));
   endfunction

   initial begin
      bit dir_press [0:19] = '{0, 0, 1, 1, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0, 0, 1, 0, 0};
      int unsigned odds;
      dur_cfg[REG_RED]          = RST_RED;
      dur_cfg[REG_RED_YELLOW]   = RST_RED_YELLOW;
      dur_cfg[REG_GREEN]        = RST_GREEN;
      dur_cfg[REG_GREEN_FLASH]  = RST_GREEN_FLASH;
      dur_cfg[REG_YELLOW]       = RST_YELLOW;
      dur_cfg[REG_DEBOUNCE]     = RST_DEBOUNCE;
      dur_cfg[REG_BLINK_PERIOD] = RST_BLINK_PERIOD;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // presses right after reset fall inside the debounce window
      @(posedge clock);
      idle_on = 1'b1;
      queue_ticks(4, 1);
      wait_idle();

      // short phases, zero green, blink every tick, ignored register slot
      csr_write(REG_RED, 16'd1);
      csr_write(REG_RED_YELLOW, 16'd1);
      csr_write(REG_GREEN, 16'd0);
      csr_write(REG_GREEN_FLASH, 16'd5);
      csr_write(REG_YELLOW, 16'd1);
      csr_write(REG_DEBOUNCE, 16'd2);
      csr_write(REG_BLINK_PERIOD, 16'd0);
      csr_write(REG_UNUSED, 16'hFFFF);
      @(posedge clock);
      foreach (dir_press[i]) tick_q.push_back(dir_press[i]);
      ticks_queued += 20;
      wait_idle();

      // widest settings: no phase expires and every press is rejected
      csr_write(REG_RED, '1);
      csr_write(REG_RED_YELLOW, '1);
      csr_write(REG_GREEN, '1);
      csr_write(REG_GREEN_FLASH, '1);
      csr_write(REG_YELLOW, '1);
      csr_write(REG_DEBOUNCE, '1);
      csr_write(REG_BLINK_PERIOD, '1);
      @(posedge clock);
      idle_on = 1'b0;
      queue_ticks(30, 4);
      wait_idle();

      for (int unsigned ph = 0; ph < 6; ph++) begin
         csr_write(REG_RED, rand_dur());
         csr_write(REG_RED_YELLOW, rand_dur());
         csr_write(REG_GREEN, rand_dur());
         csr_write(REG_GREEN_FLASH, rand_dur());
         csr_write(REG_YELLOW, rand_dur());
         csr_write(REG_DEBOUNCE, ($urandom_range(0, 3) == 0) ? dur_type'(0)
                                                             : dur_type'($urandom_range(1, 25)));
         csr_write(REG_BLINK_PERIOD, dur_type'($urandom_range(0, 6)));
         @(posedge clock);
         idle_on = (ph != 0);
         case ($urandom_range(0, 2))
            0: odds = 2;
            1: odds = 5;
            default: odds = 12;
         endcase
         queue_ticks(75, odds);
         if (ph == 2) begin
            @(posedge clock);
            hold_req = 1'b1;
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/tls_pkg.sv
design/tls_csr.sv
design/tls_step.sv
design/traffic_light_sequencer_core.sv
tb/sv/testbench.sv
